### rtl/core/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA
// block encryption engine.
// ----------------------------------------------------------------------------
package tea_pkg;

  // Word width of one half block and of one key word.
  localparam int unsigned WORD_W = 32;

  // Default number of Feistel cycles (each cycle updates both halves).
  localparam int unsigned CYCLE_COUNT_DEF = 32;

  // Golden-ratio increment of the running sum.
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Number of key words and the width of the register index.
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = $clog2(KEY_WORDS);

  typedef logic [WORD_W-1:0] tea_word_t;

  // Register index codes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } tea_reg_idx_t;

  // Two halves as they travel through the pipeline. Each stage updates x
  // from y and hands the pair on swapped, so the roles alternate.
  typedef struct packed {
    tea_word_t x;
    tea_word_t y;
  } tea_lane_t;

  // Mixing term added to one half, built from the other half.
  function automatic tea_word_t tea_mix(input tea_word_t y, input tea_word_t k_shl,
                                        input tea_word_t k_shr, input tea_word_t sum);
    tea_mix = ((y << 4) + k_shl) ^ (y + sum) ^ ((y >> 5) + k_shr);
  endfunction

endpackage

### rtl/core/tea_if.sv
// ----------------------------------------------------------------------------
// tea_if
// Valid/ready channel interfaces of the TEA engine: plaintext words,
// ciphertext words and key register writes.
// ----------------------------------------------------------------------------
interface tea_plain_if
  import tea_pkg::*;
();
  logic      valid;
  logic      ready;
  tea_word_t plain_first;
  tea_word_t plain_second;

  modport source (output valid, output plain_first, output plain_second, input ready);
  modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

interface tea_cipher_if
  import tea_pkg::*;
();
  logic      valid;
  logic      ready;
  tea_word_t cipher_first;
  tea_word_t cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

interface tea_cfg_if
  import tea_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  tea_word_t            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/tea_block_encrypt.sv
// ----------------------------------------------------------------------------
// tea_block_encrypt
// TEA block encryption engine: a fully pipelined chain of half-round stages
// that accepts one 64-bit word per cycle, while the output is not stalled, under a 128-bit key.
//
//   Channel  | Dir | Payload                          | Handshake
//   ---------+-----+----------------------------------+-------------
//   in_word  | in  | plain_first, plain_second        | valid/ready
//   out_word | out | cipher_first, cipher_second      | valid/ready
//   cfg_port | in  | index (key word), data           | valid/ready
//
// The chain has 2*CYCLE_COUNT stages, one per half-round; a new word
// enters every cycle while the result side keeps up.
// The last stage is the output register. When it holds a word that is not
// taken, the whole chain holds, and in_word.ready is low.
// Reset clears the stage valid bits and the key words; key writes are
// taken in every cycle.
// ----------------------------------------------------------------------------
module tea_block_encrypt
  import tea_pkg::*;
#(
  parameter int unsigned CYCLE_COUNT = CYCLE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tea_plain_if.sink    in_word,
  tea_cipher_if.source out_word,
  tea_cfg_if.sink      cfg_port
);

  localparam int unsigned STAGES = 2 * CYCLE_COUNT;

  tea_word_t key0_r, key1_r, key2_r, key3_r;
  tea_word_t key0_nxt, key1_nxt, key2_nxt, key3_nxt;

  logic      stage_valid [STAGES+1];
  tea_lane_t stage_lane  [STAGES+1];
  logic      advance;

  // Key word writes.
  always_comb begin
    key0_nxt = key0_r;
    key1_nxt = key1_r;
    key2_nxt = key2_r;
    key3_nxt = key3_r;
    if (cfg_port.valid) begin
      case (tea_reg_idx_t'(cfg_port.index))
        KEY_WORD0: key0_nxt = cfg_port.data;
        KEY_WORD1: key1_nxt = cfg_port.data;
        KEY_WORD2: key2_nxt = cfg_port.data;
        KEY_WORD3: key3_nxt = cfg_port.data;
        default:   key0_nxt = key0_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else begin
      key0_r <= key0_nxt;
      key1_r <= key1_nxt;
      key2_r <= key2_nxt;
      key3_r <= key3_nxt;
    end
  end

  assign cfg_port.ready = 1'b1;

  // The chain moves unless the output register holds a word not yet taken.
  assign advance       = !(stage_valid[STAGES] && !out_word.ready);
  assign in_word.ready = advance;

  assign stage_valid[0]  = in_word.valid;
  assign stage_lane[0].x = in_word.plain_first;
  assign stage_lane[0].y = in_word.plain_second;

  // Stage 2r updates the first half with key words 0/1, stage 2r+1 the
  // second half with key words 2/3; both use the sum of round r.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [2*WORD_W-1:0] SumProd =
      (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(s / 2 + 1);
    localparam tea_word_t RoundSum = SumProd[WORD_W-1:0];

    tea_half_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (stage_valid[s]),
      .in_lane   (stage_lane[s]),
      .key_shl   ((s % 2 == 0) ? key0_r : key2_r),
      .key_shr   ((s % 2 == 0) ? key1_r : key3_r),
      .round_sum (RoundSum),
      .out_valid (stage_valid[s+1]),
      .out_lane  (stage_lane[s+1])
    );
  end

  // After an even number of stages the halves are back in place.
  assign out_word.valid         = stage_valid[STAGES];
  assign out_word.cipher_first  = stage_lane[STAGES].x;
  assign out_word.cipher_second = stage_lane[STAGES].y;

endmodule

### rtl/core/tea_half_stage.sv
// ----------------------------------------------------------------------------
// tea_half_stage
// One pipeline stage of TEA: updates one half of the block from the other
// half, a pair of key words and the round sum, then registers the result.
// ----------------------------------------------------------------------------
module tea_half_stage
  import tea_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  logic      in_valid,
  input  tea_lane_t in_lane,
  input  tea_word_t key_shl,
  input  tea_word_t key_shr,
  input  tea_word_t round_sum,
  output logic      out_valid,
  output tea_lane_t out_lane
);

  logic      valid_r;
  tea_lane_t lane_r;
  tea_lane_t lane_nxt;

  // The updated half becomes the source of the next stage; the unchanged
  // half is the one the next stage updates.
  always_comb begin
    lane_nxt.x = in_lane.y;
    lane_nxt.y = in_lane.x + tea_mix(in_lane.y, key_shl, key_shr, round_sum);
  end

  // Valid bit is reset; the payload only follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;

endmodule

### rtl/core/tea_block_encrypt_chk.sv
// ----------------------------------------------------------------------------
// tea_block_encrypt_chk
// Port-level checks of the TEA engine, bound to the top level.
// ----------------------------------------------------------------------------
module tea_block_encrypt_chk
  import tea_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input tea_word_t cipher_first,
  input tea_word_t cipher_second,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // A result word that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cipher_first)
                                && $stable(cipher_second))
    else $error("result word changed while stalled");

  // A stalled output holds the whole chain, so no word may enter.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // Key writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("key write refused");

endmodule

bind tea_block_encrypt tea_block_encrypt_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_word.ready),
  .out_valid     (out_word.valid),
  .out_ready     (out_word.ready),
  .cipher_first  (out_word.cipher_first),
  .cipher_second (out_word.cipher_second),
  .cfg_valid     (cfg_port.valid),
  .cfg_ready     (cfg_port.ready)
);
